[rtl/dra_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dra_pkg: shared types and constants
// Byte-stream DNS reply parser: limits, header masks, record offsets,
// status codes and the parse phase encoding.
// ----------------------------------------------------------------------------
package dra_pkg;

  localparam int unsigned PACKET_BYTES = 512;
  localparam int unsigned POS_W        = 10;
  localparam int unsigned AIM_W        = 17;
  localparam int unsigned TYPE_LIMIT   = PACKET_BYTES - 11;

  localparam logic [7:0] RESP_MASK  = 8'h80;
  localparam logic [7:0] RCODE_MASK = 8'h0f;

  // header positions
  localparam logic [POS_W-1:0] POS_FLAGS  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_RCODE  = POS_W'(3);
  localparam logic [POS_W-1:0] POS_HDR_END = POS_W'(11);

  // question end to first record type: qtype, qclass, compressed name
  localparam logic [AIM_W-1:0] QTAIL_SKIP = AIM_W'(7);
  // record type to next record type, excluding data
  localparam logic [AIM_W-1:0] REC_FIXED  = AIM_W'(12);

  // offsets inside one answer record
  localparam logic [POS_W-1:0] OFF_TYPE_HI = POS_W'(0);
  localparam logic [POS_W-1:0] OFF_TYPE_LO = POS_W'(1);
  localparam logic [POS_W-1:0] OFF_LEN_HI  = POS_W'(8);
  localparam logic [POS_W-1:0] OFF_LEN_LO  = POS_W'(9);
  localparam logic [POS_W-1:0] OFF_ADDR_LO = POS_W'(10);
  localparam logic [POS_W-1:0] OFF_ADDR_HI = POS_W'(13);

  localparam logic [15:0] TYPE_A = 16'd1;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_BAD_REPLY = 2'd1,
    ST_LIMIT     = 2'd2,
    ST_SHORT     = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    PH_HEADER   = 5'b00001,
    PH_QUESTION = 5'b00010,
    PH_ANSWER   = 5'b00100,
    PH_CAPTURE  = 5'b01000,
    PH_IDLE     = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
  } beat_t;

  // handshake between input stage and parse stage
  typedef struct packed {
    logic  valid;
    beat_t beat;
  } stage_t;

endpackage
`default_nettype wire

[rtl/dra_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dra_in_if: reply byte channel
// Valid/ready channel carrying one reply byte and its end marker per beat.
// ----------------------------------------------------------------------------
interface dra_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       last_byte;

  modport source (output valid, output packet_byte, output last_byte, input ready);
  modport sink   (input valid, input packet_byte, input last_byte, output ready);
endinterface
`default_nettype wire

[rtl/dra_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dra_out_if: result channel
// Valid/ready channel carrying the parse status and the extracted address.
// ----------------------------------------------------------------------------
interface dra_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] ip_address;

  modport source (output valid, output status, output ip_address, input ready);
  modport sink   (input valid, input status, input ip_address, output ready);
endinterface
`default_nettype wire

[rtl/dra_in_stage.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dra_in_stage: input register
// Holds one accepted byte until the parse stage consumes it.
// ----------------------------------------------------------------------------
module dra_in_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire dra_pkg::beat_t in_beat,
  input  wire logic           advance,
  output dra_pkg::stage_t     stage
);
  import dra_pkg::*;

  logic  valid_r, valid_nxt;
  beat_t beat_r;

  assign in_ready  = !valid_r || advance;
  assign valid_nxt = (valid_r && !advance) || (in_valid && in_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat_r <= in_beat;
    end
  end

  assign stage.valid = valid_r;
  assign stage.beat  = beat_r;

endmodule
`default_nettype wire

[rtl/dra_parse.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dra_parse: reply parser and result register
// Walks header, question and answer records one byte per cycle, stalling a final
// byte while an earlier result waits, and registers the status and address on it.
// ----------------------------------------------------------------------------
module dra_parse (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire dra_pkg::stage_t stage,
  output logic                 advance,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [1:0]           out_status,
  output logic [31:0]          out_ip_address
);
  import dra_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  phase_t           phase_r, phase_nxt;
  logic [POS_W-1:0] ntp_r, ntp_nxt;
  logic [15:0]      rtype_r, rtype_nxt;
  logic [15:0]      dlen_r, dlen_nxt;
  logic [31:0]      addr_r, addr_nxt;
  status_t          code_r, code_nxt;
  logic             fixed_r, fixed_nxt;

  logic             ovalid_r, ovalid_nxt;
  logic [1:0]       ostatus_r, ostatus_nxt;
  logic [31:0]      oip_r, oip_nxt;

  logic [7:0]       b;
  logic [POS_W-1:0] off;
  logic             do_aim;
  logic [AIM_W-1:0] aim_pos;
  logic [POS_W:0]   pos_inc;
  logic             take;
  status_t          status_w;

  assign b       = stage.beat.packet_byte;
  assign off     = (pos_r >= ntp_r) ? (pos_r - ntp_r) : '0;
  assign pos_inc = {1'b0, pos_r} + (POS_W+1)'(1);
  assign advance = !stage.beat.last_byte || !ovalid_r || out_ready;
  assign take    = stage.valid && advance;

  always_comb begin
    pos_nxt   = pos_r;
    phase_nxt = phase_r;
    ntp_nxt   = ntp_r;
    rtype_nxt = rtype_r;
    dlen_nxt  = dlen_r;
    addr_nxt  = addr_r;
    code_nxt  = code_r;
    fixed_nxt = fixed_r;
    do_aim    = 1'b0;
    aim_pos   = '0;
    status_w  = ST_SHORT;

    if (take && !fixed_r && phase_r != PH_IDLE) begin
      case (phase_r)
        PH_HEADER: begin
          if (pos_r == POS_FLAGS && (b & RESP_MASK) == '0) begin
            code_nxt  = ST_BAD_REPLY;
            fixed_nxt = 1'b1;
            phase_nxt = PH_IDLE;
          end else if (pos_r == POS_RCODE && (b & RCODE_MASK) != '0) begin
            code_nxt  = ST_BAD_REPLY;
            fixed_nxt = 1'b1;
            phase_nxt = PH_IDLE;
          end else if (pos_r == POS_HDR_END) begin
            phase_nxt = PH_QUESTION;
          end
        end
        PH_QUESTION: begin
          if (b == '0) begin
            do_aim  = 1'b1;
            aim_pos = AIM_W'(pos_r) + QTAIL_SKIP;
          end
        end
        PH_ANSWER: begin
          if (pos_r >= ntp_r) begin
            if (off == OFF_TYPE_HI) begin
              rtype_nxt = {b, 8'h00};
            end else if (off == OFF_TYPE_LO) begin
              rtype_nxt = rtype_r | {8'h00, b};
            end else if (off == OFF_LEN_HI) begin
              dlen_nxt = {b, 8'h00};
            end else if (off == OFF_LEN_LO) begin
              dlen_nxt = dlen_r | {8'h00, b};
              if (rtype_r == TYPE_A) begin
                phase_nxt = PH_CAPTURE;
              end else begin
                do_aim  = 1'b1;
                aim_pos = AIM_W'(ntp_r) + REC_FIXED + AIM_W'(dlen_r | {8'h00, b});
              end
            end
          end
        end
        PH_CAPTURE: begin
          if (off >= OFF_ADDR_LO && off <= OFF_ADDR_HI) begin
            addr_nxt = {addr_r[23:0], b};
            if (off == OFF_ADDR_HI) begin
              code_nxt  = ST_FOUND;
              fixed_nxt = 1'b1;
              phase_nxt = PH_IDLE;
            end
          end
        end
        default: begin
        end
      endcase

      if (do_aim) begin
        if (aim_pos > AIM_W'(TYPE_LIMIT)) begin
          code_nxt  = ST_LIMIT;
          fixed_nxt = 1'b1;
          phase_nxt = PH_IDLE;
        end else begin
          ntp_nxt   = aim_pos[POS_W-1:0];
          phase_nxt = PH_ANSWER;
        end
      end

      // advance the position, or stop once the buffer limit is reached
      if (!fixed_nxt && phase_nxt != PH_IDLE) begin
        if (pos_inc >= (POS_W+1)'(PACKET_BYTES)) begin
          phase_nxt = PH_IDLE;
        end else begin
          pos_nxt = pos_inc[POS_W-1:0];
        end
      end
    end

    status_w = fixed_nxt ? code_nxt : ST_SHORT;

    // end of reply: report and rearm for the next one
    if (take && stage.beat.last_byte) begin
      pos_nxt   = '0;
      phase_nxt = PH_HEADER;
      ntp_nxt   = '0;
      rtype_nxt = '0;
      dlen_nxt  = '0;
      addr_nxt  = '0;
      code_nxt  = ST_FOUND;
      fixed_nxt = 1'b0;
    end
  end

  // address before the end-of-reply clear
  function automatic logic [31:0] addr_nxt_pre();
    logic [31:0] a;
    a = addr_r;
    if (take && !fixed_r && phase_r == PH_CAPTURE &&
        off >= OFF_ADDR_LO && off <= OFF_ADDR_HI) begin
      a = {addr_r[23:0], b};
    end
    return a;
  endfunction

  always_comb begin
    ovalid_nxt  = ovalid_r && !out_ready;
    ostatus_nxt = ostatus_r;
    oip_nxt     = oip_r;
    if (take && stage.beat.last_byte) begin
      ovalid_nxt  = 1'b1;
      ostatus_nxt = status_w;
      oip_nxt     = (status_w == ST_FOUND) ? addr_nxt_pre() : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      phase_r  <= PH_HEADER;
      ntp_r    <= '0;
      rtype_r  <= '0;
      dlen_r   <= '0;
      addr_r   <= '0;
      code_r   <= ST_FOUND;
      fixed_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      phase_r  <= phase_nxt;
      ntp_r    <= ntp_nxt;
      rtype_r  <= rtype_nxt;
      dlen_r   <= dlen_nxt;
      addr_r   <= addr_nxt;
      code_r   <= code_nxt;
      fixed_r  <= fixed_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ostatus_r <= ostatus_nxt;
    oip_r     <= oip_nxt;
  end

  assign out_valid      = ovalid_r;
  assign out_status     = ostatus_r;
  assign out_ip_address = oip_r;

endmodule
`default_nettype wire

[rtl/dns_response_a_record_extractor.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dns_response_a_record_extractor: DNS reply A-record extractor
// A result is registered in the output register when the parse stage takes
// the final byte from the input register. Reply bytes pass one per cycle,
// but a result waiting in the output register holds back only the next final byte.
// Reset (rst_n low, synchronous) clears the parse state and empties both
// registers; the parser also rearms itself after every final byte.
// ----------------------------------------------------------------------------
module dns_response_a_record_extractor (
  input wire logic clk,
  input wire logic rst_n,
  dra_in_if.sink   in_chan,
  dra_out_if.source out_chan
);
  import dra_pkg::*;

  stage_t stage;
  beat_t  in_beat;
  logic   advance;

  assign in_beat.packet_byte = in_chan.packet_byte;
  assign in_beat.last_byte   = in_chan.last_byte;

  dra_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .in_beat  (in_beat),
    .advance  (advance),
    .stage    (stage)
  );

  dra_parse u_parse (
    .clk            (clk),
    .rst_n          (rst_n),
    .stage          (stage),
    .advance        (advance),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .out_status     (out_chan.status),
    .out_ip_address (out_chan.ip_address)
  );

  // a failed or short reply never carries an address
  assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.status != ST_FOUND |-> out_chan.ip_address == '0)
    else $error("address present with non-found status");

  // input stalls only when the input register is occupied
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> stage.valid)
    else $error("input stalled with empty input register");

  // a held beat is not lost while the parse stage stalls
  assert property (@(posedge clk) disable iff (!rst_n)
    stage.valid && !advance |=> stage.valid && $stable(stage.beat))
    else $error("stalled beat dropped or changed");

  // a new result appears only after a final byte sat in the input register
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(stage.valid && stage.beat.last_byte))
    else $error("result without a final byte");

endmodule
`default_nettype wire

[tb/sv/tb_dns_response_a_record_extractor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dns_response_a_record_extractor: reply parser testbench
// Sends DNS replies byte by byte: a directed table of replies covering the
// header checks, question and record walking, the position limit, short and
// oversize replies, then random replies. Every result beat is checked
// against a byte-level parse predictor, or a value typed in the table.
// ----------------------------------------------------------------------------
module tb_dns_response_a_record_extractor;
  import dra_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int BYTE_GOAL   = 600;
  localparam int REPLY_GOAL  = 20;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    status_t     st;
    logic [31:0] ip;
  } answer_t;

  typedef struct packed {
    bit      typed;
    answer_t want;
  } reply_check_t;

  typedef struct packed {
    logic [7:0]  flags;
    logic [7:0]  rcode;
    int          noise_len;  // nonzero: reply is this many random bytes
    int          name_len;
    int          skip_recs;
    int          skip_dlen;
    bit          has_a;
    int          a_dlen;
    logic [31:0] addr;
    int          cut;        // nonzero: keep only this many bytes
    int          tail;
    bit          typed;
    status_t     st;
    logic [31:0] ip;
  } reply_desc_t;

  logic clk = 1'b0;
  logic rst_n;

  always #6 clk = ~clk;

  dra_in_if  in_chan();
  dra_out_if out_chan();

  dns_response_a_record_extractor u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // flags, rcode, noise, name, skip recs, skip dlen, has A, A dlen, addr,
  // cut, tail, typed, status, ip
  reply_desc_t directed_plan [21] = '{
    '{8'h81, 8'h80, 0,   0, 0,    0, 1,  4, 32'hC0A80101,  0,  0, 1, ST_FOUND, 32'hC0A80101},
    '{8'hFF, 8'hF0, 0,   3, 0,    0, 1,  4, 32'hFFFFFFFF,  0,  0, 1, ST_FOUND, 32'hFFFFFFFF},
    '{8'h80, 8'h00, 0,   5, 0,    0, 1,  4, 32'h00000000,  0,  0, 1, ST_FOUND, 32'h0},
    '{8'h00, 8'h00, 0,   2, 0,    0, 1,  4, 32'h01020304,  0,  0, 1, ST_BAD_REPLY, 32'h0},
    '{8'h7F, 8'h00, 0,   2, 0,    0, 1,  4, 32'h01020304,  0,  0, 1, ST_BAD_REPLY, 32'h0},
    '{8'h80, 8'h01, 0,   2, 0,    0, 1,  4, 32'h01020304,  0,  0, 1, ST_BAD_REPLY, 32'h0},
    '{8'h80, 8'h0F, 0,   2, 0,    0, 1,  4, 32'h01020304,  0, 20, 1, ST_BAD_REPLY, 32'h0},
    '{8'h80, 8'h00, 0,   2, 0,    0, 1,  4, 32'h01020304,  1,  0, 1, ST_SHORT, 32'h0},
    '{8'h80, 8'h00, 0,   2, 0,    0, 1,  4, 32'h01020304, 13,  0, 1, ST_SHORT, 32'h0},
    '{8'h80, 8'h00, 0, 495, 0,    0, 1,  4, 32'h0A000001,  0,  0, 1, ST_LIMIT, 32'h0},
    '{8'h80, 8'h00, 0, 482, 0,    0, 1,  4, 32'h0A000002,  0,  0, 0, ST_FOUND, 32'h0},
    '{8'h80, 8'h00, 0, 483, 0,    0, 1,  4, 32'h0A000004,  0,  0, 1, ST_LIMIT, 32'h0},
    '{8'h80, 8'h00, 0,   0, 1, 1000, 1,  4, 32'h0A000003, 40,  0, 1, ST_LIMIT, 32'h0},
    '{8'h80, 8'h00, 0,   4, 0,    0, 1,  0, 32'hAC100001,  0,  0, 1, ST_FOUND, 32'hAC100001},
    '{8'h80, 8'h00, 0,   4, 0,    0, 1,  2, 32'hAC100002,  0,  0, 1, ST_FOUND, 32'hAC100002},
    '{8'h80, 8'h00, 0,   7, 2,    6, 1,  4, 32'h08080808,  0,  0, 1, ST_FOUND, 32'h08080808},
    '{8'h80, 8'h00, 0,   3, 1,    4, 0,  4, 32'h09090909,  0,  0, 1, ST_SHORT, 32'h0},
    '{8'h80, 8'h00, 0, 600, 0,    0, 1,  4, 32'h0B0B0B0B,  0,  0, 1, ST_SHORT, 32'h0},
    '{8'h80, 8'h00, 0,   6, 0,    0, 1,  8, 32'h7F000001,  0, 10, 1, ST_FOUND, 32'h7F000001},
    '{8'h80, 8'h00, 0,   9, 3,    0, 1, 16, 32'h5A5AA5A5,  0,  0, 0, ST_FOUND, 32'h0},
    '{8'h80, 8'h00, 1,   0, 0,    0, 0,  0, 32'h0,         0,  0, 0, ST_FOUND, 32'h0}
  };

  // parse state of the predictor
  logic [POS_W-1:0] ps_pos;
  phase_t           ps_phase;
  logic [AIM_W-1:0] ps_aim;
  logic [15:0]      ps_type;
  logic [15:0]      ps_len;
  logic [31:0]      ps_addr;
  status_t          ps_code;
  logic             ps_fixed;

  answer_t      expected_answers [$];
  reply_check_t reply_checks [$];
  logic [7:0]   reply_bytes [$];

  int fail_count   = 0;
  int cycle_count  = 0;
  int random_bytes = 0;
  int replies_sent = 0;
  bit in_random    = 1'b0;
  bit steady       = 1'b0;
  bit gaps_on      = 1'b0;
  bit parked       = 1'b0;
  bit hold_done    = 1'b0;

  task clear_parse_state();
    ps_pos   = '0;
    ps_phase = PH_HEADER;
    ps_aim   = '0;
    ps_type  = '0;
    ps_len   = '0;
    ps_addr  = '0;
    ps_code  = ST_FOUND;
    ps_fixed = 1'b0;
  endtask

  task settle_outcome(input status_t code);
    ps_code  = code;
    ps_fixed = 1'b1;
    ps_phase = PH_IDLE;
  endtask

  task aim_record(input logic [AIM_W-1:0] p);
    if (p > TYPE_LIMIT) begin
      settle_outcome(ST_LIMIT);
    end else begin
      ps_aim   = p;
      ps_phase = PH_ANSWER;
    end
  endtask

  task parse_reply_byte(input logic [7:0] b, input logic last, output bit done,
                        output answer_t res);
    int unsigned pos;
    int unsigned off;
    done = 1'b0;
    res  = '0;
    if (!ps_fixed && ps_phase != PH_IDLE) begin
      pos = ps_pos;
      off = (pos >= ps_aim) ? pos - ps_aim : 0;
      case (ps_phase)
        PH_HEADER: begin
          if (pos == POS_FLAGS && (b & RESP_MASK) == 8'h00)
            settle_outcome(ST_BAD_REPLY);
          else if (pos == POS_RCODE && (b & RCODE_MASK) != 8'h00)
            settle_outcome(ST_BAD_REPLY);
          else if (pos == POS_HDR_END)
            ps_phase = PH_QUESTION;
        end
        PH_QUESTION: begin
          if (b == 8'h00)
            aim_record(AIM_W'(pos) + QTAIL_SKIP);
        end
        PH_ANSWER: begin
          if (pos >= ps_aim) begin
            if (off == OFF_TYPE_HI) begin
              ps_type = {b, 8'h00};
            end else if (off == OFF_TYPE_LO) begin
              ps_type = {ps_type[15:8], b};
            end else if (off == OFF_LEN_HI) begin
              ps_len = {b, 8'h00};
            end else if (off == OFF_LEN_LO) begin
              ps_len = {ps_len[15:8], b};
              if (ps_type == TYPE_A)
                ps_phase = PH_CAPTURE;
              else
                aim_record(ps_aim + REC_FIXED + AIM_W'(ps_len));
            end
          end
        end
        PH_CAPTURE: begin
          // address is always offsets 10..13, whatever the data length says
          if (off >= OFF_ADDR_LO && off <= OFF_ADDR_HI) begin
            ps_addr = {ps_addr[23:0], b};
            if (off == OFF_ADDR_HI)
              settle_outcome(ST_FOUND);
          end
        end
        default: ;
      endcase
      if (!ps_fixed && ps_phase != PH_IDLE) begin
        // stop parsing at the packet size limit
        if (pos + 1 >= PACKET_BYTES || pos + 1 > (1 << POS_W) - 1)
          ps_phase = PH_IDLE;
        else
          ps_pos = POS_W'(pos + 1);
      end
    end
    if (last) begin
      done   = 1'b1;
      res.st = ps_fixed ? ps_code : ST_SHORT;
      res.ip = (res.st == ST_FOUND) ? ps_addr : 32'h0;
      clear_parse_state();
    end
  endtask

  task build_reply(input reply_desc_t d);
    logic [15:0] rtype;
    logic [15:0] dlen;
    reply_bytes.delete();
    if (d.noise_len != 0) begin
      repeat (d.noise_len) reply_bytes.push_back(8'($urandom));
    end else begin
      reply_bytes.push_back(8'($urandom));
      reply_bytes.push_back(8'($urandom));
      reply_bytes.push_back(d.flags);
      reply_bytes.push_back(d.rcode);
      repeat (8) reply_bytes.push_back(8'($urandom));
      repeat (d.name_len) reply_bytes.push_back(8'($urandom_range(1, 255)));
      reply_bytes.push_back(8'h00);
      repeat (4) reply_bytes.push_back(8'($urandom));
      dlen = d.skip_dlen[15:0];
      repeat (d.skip_recs) begin
        rtype = 16'($urandom);
        if (rtype == TYPE_A)
          rtype = 16'h0101;
        reply_bytes.push_back(8'hC0);
        reply_bytes.push_back(8'h0C);
        reply_bytes.push_back(rtype[15:8]);
        reply_bytes.push_back(rtype[7:0]);
        repeat (6) reply_bytes.push_back(8'($urandom));
        reply_bytes.push_back(dlen[15:8]);
        reply_bytes.push_back(dlen[7:0]);
        // cap the data of long records; the parse gives up on any that aims past the type limit
        repeat ((d.skip_dlen > 64) ? 64 : d.skip_dlen) reply_bytes.push_back(8'($urandom));
      end
      if (d.has_a) begin
        dlen = d.a_dlen[15:0];
        reply_bytes.push_back(8'hC0);
        reply_bytes.push_back(8'h0C);
        reply_bytes.push_back(TYPE_A[15:8]);
        reply_bytes.push_back(TYPE_A[7:0]);
        repeat (6) reply_bytes.push_back(8'($urandom));
        reply_bytes.push_back(dlen[15:8]);
        reply_bytes.push_back(dlen[7:0]);
        reply_bytes.push_back(d.addr[31:24]);
        reply_bytes.push_back(d.addr[23:16]);
        reply_bytes.push_back(d.addr[15:8]);
        reply_bytes.push_back(d.addr[7:0]);
        repeat ((d.a_dlen > 4) ? d.a_dlen - 4 : 0) reply_bytes.push_back(8'($urandom));
      end
      repeat (d.tail) reply_bytes.push_back(8'($urandom));
    end
    if (d.cut != 0 && d.cut < reply_bytes.size())
      reply_bytes = reply_bytes[0:d.cut-1];
  endtask

  task make_random_reply(output reply_desc_t d);
    d           = '0;
    d.flags     = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom) | RESP_MASK;
    d.rcode     = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom) & ~RCODE_MASK;
    d.name_len  = ($urandom_range(0, 99) == 0) ? $urandom_range(470, 520)
                                                : $urandom_range(0, 30);
    d.skip_recs = $urandom_range(0, 3);
    d.skip_dlen = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 12);
    d.has_a     = ($urandom_range(0, 9) != 0);
    d.a_dlen    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 4;
    d.addr      = $urandom;
    d.cut       = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 60) : 0;
    d.tail      = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    // short junk while the receiver is parked, so results pile up
    if (parked)
      d.noise_len = $urandom_range(1, 3);
    else if ($urandom_range(0, 11) == 0)
      d.noise_len = $urandom_range(1, 40);
  endtask

  // called at a falling edge, returns at the falling edge after the beat
  task send_byte(input logic [7:0] b, input logic last);
    if (gaps_on && !steady && $urandom_range(0, 5) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.packet_byte <= b;
    in_chan.last_byte   <= last;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
    if (in_random)
      random_bytes++;
  endtask

  task send_reply(input reply_desc_t d);
    reply_check_t rc;
    build_reply(d);
    rc.typed   = d.typed;
    rc.want.st = d.st;
    rc.want.ip = d.ip;
    reply_checks.push_back(rc);
    gaps_on = ($urandom_range(0, 3) != 0);
    foreach (reply_bytes[i])
      send_byte(reply_bytes[i], i == reply_bytes.size() - 1);
    replies_sent++;
  endtask

  task wait_for_answers();
    in_chan.valid <= 1'b0;
    do @(negedge clk); while (expected_answers.size() != 0);
  endtask

  initial begin
    reply_desc_t d;
    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.packet_byte = 8'h00;
    in_chan.last_byte   = 1'b0;
    clear_parse_state();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_plan[i])
      send_reply(directed_plan[i]);
    wait_for_answers();

    in_random    = 1'b1;
    replies_sent = 0;
    while (random_bytes < BYTE_GOAL || replies_sent < REPLY_GOAL) begin
      if (random_bytes >= 350 && random_bytes < 450 && !parked)
        wait_for_answers();
      steady = (random_bytes >= BYTE_GOAL - 150);
      make_random_reply(d);
      send_reply(d);
    end

    wait_for_answers();
    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("dns_response_a_record_extractor test passed");
    else
      $display("dns_response_a_record_extractor test failed");
    $finish;
  end

  initial begin
    int  stretch;
    bit  idle_on;
    stretch        = 0;
    idle_on        = 1'b0;
    out_chan.ready = 1'b0;
    wait (rst_n);
    forever begin
      if (stretch == 0) begin
        stretch = $urandom_range(20, 150);
        idle_on = ($urandom_range(0, 2) != 0);
      end
      stretch--;
      if (!hold_done && random_bytes >= 150) begin
        // long hold-off: let the block back up into its input
        hold_done      = 1'b1;
        parked         = 1'b1;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        parked = 1'b0;
      end else if (idle_on && !steady && $urandom_range(0, 5) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin : watch_in
    bit           done;
    answer_t      res;
    reply_check_t rc;
    if (rst_n && in_chan.valid && in_chan.ready) begin
      parse_reply_byte(in_chan.packet_byte, in_chan.last_byte, done, res);
      if (done) begin
        rc = reply_checks.pop_front();
        expected_answers.push_back(rc.typed ? rc.want : res);
      end
    end
  end

  always @(posedge clk) begin : watch_out
    answer_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_answers.size() == 0) begin
        $error("unexpected result beat: status %0d ip %h", out_chan.status,
               out_chan.ip_address);
        fail_count++;
      end else begin
        want = expected_answers.pop_front();
        if (out_chan.status !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, out_chan.status);
          fail_count++;
        end
        if (out_chan.ip_address !== want.ip) begin
          $error("ip_address: expected %h, got %h", want.ip, out_chan.ip_address);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("dns_response_a_record_extractor test failed");
      $finish;
    end
  end

endmodule
